### rtl/core/tlvd_pkg.sv
package tlvd_pkg;

  // Dump size limit and the widths that follow from it.
  localparam int unsigned MaxBytes = 4096;
  localparam int unsigned PosW     = $clog2(MaxBytes + 1);

  // Byte that marks filler at a record boundary.
  localparam logic [7:0] FillerByte = 8'hFF;

  // Record types that count as known.
  localparam logic [7:0] TypeFirst = 8'h01;
  localparam logic [7:0] TypeLast  = 8'h03;

  // Result queue depth; one input byte causes at most two results.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Parser phases.
  localparam logic [2:0] PhBoundary = 3'd0;
  localparam logic [2:0] PhRun      = 3'd1;
  localparam logic [2:0] PhSize     = 3'd2;
  localparam logic [2:0] PhPayload  = 3'd3;
  localparam logic [2:0] PhCheck    = 3'd4;

  typedef enum logic [2:0] {
    KindRun       = 3'd0,
    KindValid     = 3'd1,
    KindUnknown   = 3'd2,
    KindCorrupted = 3'd3,
    KindTruncated = 3'd4,
    KindTotals    = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] offset;
    logic [7:0]  record_type;
    logic [7:0]  record_size;
    logic [7:0]  checksum_computed;
    logic [7:0]  checksum_read;
    logic [12:0] run_length;
    logic [10:0] records_found;
    logic [12:0] garbage_total;
    logic        last;
  } result_t;

endpackage

### rtl/core/tlv_record_deframer_top.sv
// Splits a byte dump into filler runs and type/size/payload/checksum records and reports each
// one as a result beat, followed by a totals beat when a byte marked end_of_dump arrives. Bytes
// are taken one per cycle: a byte sits in an input register while the parser state and up to
// two results are worked out, and the results go into a four-entry result queue. The queue
// sets the rate: a byte is taken while the queue holds at most two results, so with the output
// side always ready the block sustains one byte per cycle, and a byte that causes two results
// can hold up the bytes behind it. Only the first 4096 bytes of a dump are parsed; later bytes
// are skipped but their end_of_dump mark still closes the dump.
module tlv_record_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_dump_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [11:0] offset_o,
  output logic [7:0]  record_type_o,
  output logic [7:0]  record_size_o,
  output logic [7:0]  checksum_computed_o,
  output logic [7:0]  checksum_read_o,
  output logic [12:0] run_length_o,
  output logic [10:0] records_found_o,
  output logic [12:0] garbage_total_o,
  output logic        last_o
);

  localparam int unsigned PosW = tlvd_pkg::PosW;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;
  logic       s1_fire;

  // Parser state.
  logic [2:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [11:0]     rec_start_q, rec_start_d;
  logic [7:0]      type_q, type_d;
  logic [7:0]      size_q, size_d;
  logic [7:0]      left_q, left_d;
  logic [7:0]      xor_q, xor_d;
  logic [11:0]     run_start_q, run_start_d;
  logic [12:0]     run_count_q, run_count_d;
  logic [10:0]     valid_count_q, valid_count_d;
  logic [12:0]     filler_count_q, filler_count_d;
  logic            ovf_q, ovf_d;

  // Results of the byte in the input register.
  tlvd_pkg::result_t res [2];
  logic [1:0]        res_cnt;

  // Result queue.
  localparam logic [tlvd_pkg::QPtrW-1:0] QPtrW1 = tlvd_pkg::QPtrW'(1);

  tlvd_pkg::result_t              q_mem [tlvd_pkg::QDepth];
  logic [tlvd_pkg::QPtrW-1:0]     q_wr_q, q_rd_q;
  logic [tlvd_pkg::QCntW-1:0]     q_cnt_q;
  logic                           q_pop;
  logic                           q_room;

  // A byte leaves the input register when the queue can take two results.
  assign q_room     = q_cnt_q <= tlvd_pkg::QCntW'(tlvd_pkg::QDepth - 2);
  assign s1_fire    = s1_valid_q && q_room;
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_end_q  <= end_of_dump_i;
    end
  end

  // Parser step and result building for one byte.
  always_comb begin
    tlvd_pkg::result_t blank;
    logic [2:0]        ph;

    blank          = '0;
    blank.kind     = tlvd_pkg::KindRun;
    res[0]         = blank;
    res[1]         = blank;
    res_cnt        = 2'd0;

    phase_d        = phase_q;
    pos_d          = pos_q;
    rec_start_d    = rec_start_q;
    type_d         = type_q;
    size_d         = size_q;
    left_d         = left_q;
    xor_d          = xor_q;
    run_start_d    = run_start_q;
    run_count_d    = run_count_q;
    valid_count_d  = valid_count_q;
    filler_count_d = filler_count_q;
    ovf_d          = ovf_q;
    ph             = phase_q;

    if (!ovf_q) begin
      // A byte other than filler closes a run before it is parsed.
      if (ph == tlvd_pkg::PhRun && s1_byte_q != tlvd_pkg::FillerByte) begin
        res[res_cnt[0]].kind       = tlvd_pkg::KindRun;
        res[res_cnt[0]].offset     = run_start_q;
        res[res_cnt[0]].run_length = run_count_q;
        res_cnt                    = res_cnt + 2'd1;
        ph                         = tlvd_pkg::PhBoundary;
      end

      unique case (ph)
        tlvd_pkg::PhBoundary: begin
          if (s1_byte_q == tlvd_pkg::FillerByte) begin
            run_start_d    = 12'(pos_q);
            run_count_d    = 13'd1;
            filler_count_d = filler_count_q + 13'd1;
            phase_d        = tlvd_pkg::PhRun;
          end else begin
            rec_start_d = 12'(pos_q);
            type_d      = s1_byte_q;
            size_d      = 8'd0;
            xor_d       = 8'd0;
            phase_d     = tlvd_pkg::PhSize;
          end
        end
        tlvd_pkg::PhRun: begin
          run_count_d    = run_count_q + 13'd1;
          filler_count_d = filler_count_q + 13'd1;
        end
        tlvd_pkg::PhSize: begin
          size_d  = s1_byte_q;
          left_d  = s1_byte_q;
          phase_d = (s1_byte_q != 8'd0) ? tlvd_pkg::PhPayload : tlvd_pkg::PhCheck;
        end
        tlvd_pkg::PhPayload: begin
          xor_d  = xor_q ^ s1_byte_q;
          left_d = left_q - 8'd1;
          if (left_d == 8'd0) begin
            phase_d = tlvd_pkg::PhCheck;
          end
        end
        tlvd_pkg::PhCheck: begin
          if (s1_byte_q != xor_q) begin
            res[res_cnt[0]].kind = tlvd_pkg::KindCorrupted;
          end else if (type_q >= tlvd_pkg::TypeFirst && type_q <= tlvd_pkg::TypeLast) begin
            res[res_cnt[0]].kind = tlvd_pkg::KindValid;
            valid_count_d        = valid_count_q + 11'd1;
          end else begin
            res[res_cnt[0]].kind = tlvd_pkg::KindUnknown;
            filler_count_d       = filler_count_q + 13'(size_q) + 13'd3;
          end
          res[res_cnt[0]].offset            = rec_start_q;
          res[res_cnt[0]].record_type       = type_q;
          res[res_cnt[0]].record_size       = size_q;
          res[res_cnt[0]].checksum_computed = xor_q;
          res[res_cnt[0]].checksum_read     = s1_byte_q;
          res_cnt                           = res_cnt + 2'd1;
          phase_d                           = tlvd_pkg::PhBoundary;
        end
        default: begin
          phase_d = tlvd_pkg::PhBoundary;
        end
      endcase

      pos_d = pos_q + PosW'(1);
      if (pos_d == PosW'(tlvd_pkg::MaxBytes)) begin
        ovf_d = 1'b1;
      end
    end

    // End of dump: flush an open run or a truncated record, then the totals.
    if (s1_end_q) begin
      if (phase_d == tlvd_pkg::PhRun) begin
        res[res_cnt[0]].kind       = tlvd_pkg::KindRun;
        res[res_cnt[0]].offset     = run_start_d;
        res[res_cnt[0]].run_length = run_count_d;
        res_cnt                    = res_cnt + 2'd1;
      end else if ((phase_d == tlvd_pkg::PhPayload || phase_d == tlvd_pkg::PhCheck) &&
                   left_d != size_d) begin
        // At least one payload byte was seen, so the record has three or more bytes.
        res[res_cnt[0]].kind        = tlvd_pkg::KindTruncated;
        res[res_cnt[0]].offset      = rec_start_d;
        res[res_cnt[0]].record_type = type_d;
        res[res_cnt[0]].record_size = size_d;
        res_cnt                     = res_cnt + 2'd1;
      end
      res[res_cnt[0]].kind          = tlvd_pkg::KindTotals;
      res[res_cnt[0]].records_found = valid_count_d;
      res[res_cnt[0]].garbage_total = filler_count_d;
      res_cnt                       = res_cnt + 2'd1;

      phase_d        = tlvd_pkg::PhBoundary;
      pos_d          = '0;
      rec_start_d    = '0;
      type_d         = '0;
      size_d         = '0;
      left_d         = '0;
      xor_d          = '0;
      run_start_d    = '0;
      run_count_d    = '0;
      valid_count_d  = '0;
      filler_count_d = '0;
      ovf_d          = 1'b0;
    end

    // Mark the final result of this byte.
    if (res_cnt == 2'd2) begin
      res[1].last = 1'b1;
    end else if (res_cnt == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= tlvd_pkg::PhBoundary;
      pos_q          <= '0;
      rec_start_q    <= '0;
      type_q         <= '0;
      size_q         <= '0;
      left_q         <= '0;
      xor_q          <= '0;
      run_start_q    <= '0;
      run_count_q    <= '0;
      valid_count_q  <= '0;
      filler_count_q <= '0;
      ovf_q          <= 1'b0;
    end else if (s1_fire) begin
      phase_q        <= phase_d;
      pos_q          <= pos_d;
      rec_start_q    <= rec_start_d;
      type_q         <= type_d;
      size_q         <= size_d;
      left_q         <= left_d;
      xor_q          <= xor_d;
      run_start_q    <= run_start_d;
      run_count_q    <= run_count_d;
      valid_count_q  <= valid_count_d;
      filler_count_q <= filler_count_d;
      ovf_q          <= ovf_d;
    end
  end

  // Result queue: up to two beats pushed, one beat popped per cycle.
  assign q_pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_cnt != 2'd0) begin
      q_mem[q_wr_q] <= res[0];
    end
    if (s1_fire && res_cnt == 2'd2) begin
      q_mem[q_wr_q + QPtrW1] <= res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (s1_fire) begin
        q_wr_q <= q_wr_q + tlvd_pkg::QPtrW'(res_cnt);
      end
      if (q_pop) begin
        q_rd_q <= q_rd_q + QPtrW1;
      end
      q_cnt_q <= q_cnt_q + (s1_fire ? tlvd_pkg::QCntW'(res_cnt) : '0)
                 - tlvd_pkg::QCntW'(q_pop);
    end
  end

  assign out_valid_o         = q_cnt_q != '0;
  assign kind_o              = q_mem[q_rd_q].kind;
  assign offset_o            = q_mem[q_rd_q].offset;
  assign record_type_o       = q_mem[q_rd_q].record_type;
  assign record_size_o       = q_mem[q_rd_q].record_size;
  assign checksum_computed_o = q_mem[q_rd_q].checksum_computed;
  assign checksum_read_o     = q_mem[q_rd_q].checksum_read;
  assign run_length_o        = q_mem[q_rd_q].run_length;
  assign records_found_o     = q_mem[q_rd_q].records_found;
  assign garbage_total_o     = q_mem[q_rd_q].garbage_total;
  assign last_o              = q_mem[q_rd_q].last;

  // The queue never holds more beats than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= tlvd_pkg::QCntW'(tlvd_pkg::QDepth))
    else $error("result queue overfilled");

  // A byte that ends the dump leaves the parser at offset zero at a boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_end_q |=> phase_q == tlvd_pkg::PhBoundary && pos_q == '0 && !ovf_q)
    else $error("parser not cleared after end of dump");

  // Bytes are skipped only once the size limit has been reached.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> pos_q == PosW'(tlvd_pkg::MaxBytes))
    else $error("size limit flag without full dump");

  // An open filler run always holds at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tlvd_pkg::PhRun |-> run_count_q != '0)
    else $error("empty filler run");

  // A byte that ends the dump always pushes a totals beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_end_q |-> res_cnt != 2'd0)
    else $error("end of dump without totals");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MaxGap      = 6;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomBytes = 420;

  // Tracks the parser state of the current dump and holds the result beats still owed.
  class tlv_scoreboard;
    logic [2:0]        phase;
    logic [12:0]       pos;
    logic [11:0]       rec_start;
    logic [11:0]       run_start;
    logic [7:0]        rec_type;
    logic [7:0]        rec_size;
    logic [7:0]        left;
    logic [7:0]        xsum;
    logic [8:0]        rec_bytes;
    logic [12:0]       run_len;
    logic [12:0]       garbage;
    logic [10:0]       good_recs;
    bit                past_limit;
    tlvd_pkg::result_t owed_reports[$];
    int unsigned       errors;
    int unsigned       beats_checked;
    int unsigned       kind_seen[6];

    // The parser state returns to its power-up value at the start of a dump.
    function void restart_dump();
      phase      = tlvd_pkg::PhBoundary;
      pos        = '0;
      rec_start  = '0;
      run_start  = '0;
      rec_type   = '0;
      rec_size   = '0;
      left       = '0;
      xsum       = '0;
      rec_bytes  = '0;
      run_len    = '0;
      garbage    = '0;
      good_recs  = '0;
      past_limit = 1'b0;
    endfunction

    function tlvd_pkg::result_t report(tlvd_pkg::kind_e k, logic [11:0] off,
                                       logic [7:0] typ, logic [7:0] siz,
                                       logic [7:0] cc, logic [7:0] cr, logic [12:0] rl,
                                       logic [10:0] rf, logic [12:0] gt);
      tlvd_pkg::result_t r;
      r.kind              = k;
      r.offset            = off;
      r.record_type       = typ;
      r.record_size       = siz;
      r.checksum_computed = cc;
      r.checksum_read     = cr;
      r.run_length        = rl;
      r.records_found     = rf;
      r.garbage_total     = gt;
      r.last              = 1'b0;
      return r;
    endfunction

    // Advances the parser by one accepted byte and queues the beats it causes.
    function void take_byte(logic [7:0] b, logic eod);
      tlvd_pkg::result_t step_out[2];
      tlvd_pkg::kind_e   k;
      int                n;
      n = 0;
      if (!past_limit) begin
        // A byte other than filler closes an open run before anything else.
        if (phase == tlvd_pkg::PhRun && b != tlvd_pkg::FillerByte) begin
          step_out[n] = report(tlvd_pkg::KindRun, run_start, '0, '0, '0, '0, run_len,
                               '0, '0);
          n++;
          phase = tlvd_pkg::PhBoundary;
        end
        case (phase)
          tlvd_pkg::PhBoundary: begin
            if (b == tlvd_pkg::FillerByte) begin
              run_start = pos[11:0];
              run_len   = 13'd1;
              garbage   = garbage + 13'd1;
              phase     = tlvd_pkg::PhRun;
            end else begin
              rec_start = pos[11:0];
              rec_type  = b;
              rec_size  = '0;
              xsum      = '0;
              rec_bytes = 9'd1;
              phase     = tlvd_pkg::PhSize;
            end
          end
          tlvd_pkg::PhRun: begin
            run_len = run_len + 13'd1;
            garbage = garbage + 13'd1;
          end
          tlvd_pkg::PhSize: begin
            rec_size  = b;
            left      = b;
            rec_bytes = 9'd2;
            phase     = (b != 8'd0) ? tlvd_pkg::PhPayload : tlvd_pkg::PhCheck;
          end
          tlvd_pkg::PhPayload: begin
            xsum      = xsum ^ b;
            rec_bytes = rec_bytes + 9'd1;
            left      = left - 8'd1;
            if (left == 8'd0) phase = tlvd_pkg::PhCheck;
          end
          default: begin
            // Checksum byte: a bad sum wins over the type test.
            if (b != xsum) begin
              k = tlvd_pkg::KindCorrupted;
            end else if (rec_type >= tlvd_pkg::TypeFirst &&
                         rec_type <= tlvd_pkg::TypeLast) begin
              k = tlvd_pkg::KindValid;
              good_recs = good_recs + 11'd1;
            end else begin
              k = tlvd_pkg::KindUnknown;
              garbage = garbage + 13'(rec_size) + 13'd3;
            end
            step_out[n] = report(k, rec_start, rec_type, rec_size, xsum, b, '0, '0, '0);
            n++;
            phase     = tlvd_pkg::PhBoundary;
            rec_bytes = '0;
          end
        endcase
        pos = pos + 13'd1;
        if (pos >= tlvd_pkg::MaxBytes) past_limit = 1'b1;
      end

      // End of dump: flush the open run or a long enough partial record, then totals.
      if (eod) begin
        if (phase == tlvd_pkg::PhRun) begin
          step_out[n] = report(tlvd_pkg::KindRun, run_start, '0, '0, '0, '0, run_len,
                               '0, '0);
          n++;
        end else if (phase != tlvd_pkg::PhBoundary && rec_bytes >= 9'd3) begin
          step_out[n] = report(tlvd_pkg::KindTruncated, rec_start, rec_type, rec_size,
                               '0, '0, '0, '0, '0);
          n++;
        end
        step_out[n] = report(tlvd_pkg::KindTotals, '0, '0, '0, '0, '0, '0, good_recs,
                             garbage);
        n++;
        restart_dump();
      end

      if (n > 0) step_out[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) owed_reports.push_back(step_out[i]);
    endfunction

    function int field_bad(string name, logic [12:0] want_v, logic [12:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        return 1;
      end
      return 0;
    endfunction

    // Compares one output beat with the oldest owed report.
    function void check_beat(tlvd_pkg::result_t got);
      tlvd_pkg::result_t want;
      int                bad;
      beats_checked++;
      if (!$isunknown(got.kind) && got.kind <= tlvd_pkg::KindTotals) kind_seen[got.kind]++;
      if (owed_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got kind %0d offset %0d",
                 $time, got.kind, got.offset);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      bad = field_bad("kind", 13'(want.kind), 13'(got.kind))
          + field_bad("offset", 13'(want.offset), 13'(got.offset))
          + field_bad("record_type", 13'(want.record_type), 13'(got.record_type))
          + field_bad("record_size", 13'(want.record_size), 13'(got.record_size))
          + field_bad("checksum_computed", 13'(want.checksum_computed),
                      13'(got.checksum_computed))
          + field_bad("checksum_read", 13'(want.checksum_read), 13'(got.checksum_read))
          + field_bad("run_length", want.run_length, got.run_length)
          + field_bad("records_found", 13'(want.records_found), 13'(got.records_found))
          + field_bad("garbage_total", want.garbage_total, got.garbage_total)
          + field_bad("last", 13'(want.last), 13'(got.last));
      if (bad != 0) errors++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_dump_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  kind_o;
  logic [11:0] offset_o;
  logic [7:0]  record_type_o;
  logic [7:0]  record_size_o;
  logic [7:0]  checksum_computed_o;
  logic [7:0]  checksum_read_o;
  logic [12:0] run_length_o;
  logic [10:0] records_found_o;
  logic [12:0] garbage_total_o;
  logic        last_o;

  tlv_scoreboard     sb;
  tlvd_pkg::result_t out_beat;
  logic [7:0]        dump_q[$];
  bit                fast_mode = 1'b0;
  bit                hold_req = 1'b0;
  int unsigned       quiet_cycles = 0;
  int unsigned       dumps_sent = 0;
  int unsigned       bytes_taken = 0;
  int unsigned       random_bytes = 0;

  tlv_record_deframer_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .end_of_dump_i       (end_of_dump_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .offset_o            (offset_o),
    .record_type_o       (record_type_o),
    .record_size_o       (record_size_o),
    .checksum_computed_o (checksum_computed_o),
    .checksum_read_o     (checksum_read_o),
    .run_length_o        (run_length_o),
    .records_found_o     (records_found_o),
    .garbage_total_o     (garbage_total_o),
    .last_o              (last_o)
  );

  // Clock, 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Gather the output ports into one beat.
  always_comb begin
    out_beat.kind              = tlvd_pkg::kind_e'(kind_o);
    out_beat.offset            = offset_o;
    out_beat.record_type       = record_type_o;
    out_beat.record_size       = record_size_o;
    out_beat.checksum_computed = checksum_computed_o;
    out_beat.checksum_read     = checksum_read_o;
    out_beat.run_length        = run_length_o;
    out_beat.records_found     = records_found_o;
    out_beat.garbage_total     = garbage_total_o;
    out_beat.last              = last_o;
  end

  // Both handshakes are sampled at the rising edge; the input beat is noted first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.take_byte(data_byte_i, end_of_dump_i);
        bytes_taken++;
      end
      if (out_valid_o && out_ready_i) sb.check_beat(out_beat);
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls per beat, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      stall = fast_mode ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one byte after a random gap and holds it until the block takes it.
  task automatic send_byte(logic [7:0] b, logic eod);
    int unsigned gap;
    gap = fast_mode ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_dump_i <= eod;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_dump();
    for (int i = 0; i < dump_q.size(); i++) send_byte(dump_q[i], i == dump_q.size() - 1);
    dumps_sent++;
  endtask

  // Appends a type/size/payload/checksum record, with a good or a broken sum.
  function automatic void add_record(logic [7:0] typ, int unsigned size, bit good_sum);
    logic [7:0] x;
    logic [7:0] p;
    x = '0;
    dump_q.push_back(typ);
    dump_q.push_back(size[7:0]);
    for (int i = 0; i < size; i++) begin
      p = 8'($urandom);
      x = x ^ p;
      dump_q.push_back(p);
    end
    dump_q.push_back(good_sum ? x : x ^ 8'($urandom_range(1, 255)));
  endfunction

  function automatic void add_run(int unsigned len);
    repeat (len) dump_q.push_back(tlvd_pkg::FillerByte);
  endfunction

  // Mostly well-formed records, with runs and noise mixed in; some dumps are cut short.
  function automatic void add_random_dump();
    int unsigned segs;
    int unsigned pick;
    int unsigned size;
    int unsigned cut;
    logic [7:0]  typ;
    dump_q.delete();
    segs = $urandom_range(1, 5);
    repeat (segs) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) typ = 8'($urandom_range(1, 3));
        else if (pick < 8) typ = 8'($urandom_range(4, 254));
        else typ = (pick == 8) ? 8'h00 : 8'hFE;
        size = ($urandom_range(0, 99) < 3) ? $urandom_range(64, 255) : $urandom_range(0, 6);
        add_record(typ, size, $urandom_range(0, 99) < 85);
      end else if (pick < 85) begin
        add_run($urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 4)) dump_q.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, dump_q.size());
      dump_q = dump_q[0:cut-1];
    end
  endfunction

  // Main sequence: reset, directed dumps, then random dumps.
  initial begin
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    end_of_dump_i = 1'b0;
    rst_ni        = 1'b0;
    sb = new;
    sb.restart_dump();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A lone filler byte, then a lone record byte that is too short to report.
    dump_q = '{8'hFF};
    send_dump();
    dump_q = '{8'h01};
    send_dump();
    // Valid record, a run closed by a record, unknown types 7 and 0, truncated tail.
    dump_q = '{8'h01, 8'h02, 8'hAA, 8'h55, 8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h00};
    send_dump();
    // Corrupted record, then a two-byte tail that stays silent.
    dump_q = '{8'h03, 8'h01, 8'h10, 8'h11, 8'h7F, 8'h00};
    send_dump();
    // Empty record completing on the final byte: record beat and totals together.
    dump_q = '{8'h03, 8'h00, 8'h00};
    send_dump();

    // Random dumps; the receiver starts with a long hold-off so the block backs up.
    hold_req = 1'b1;
    while (random_bytes < RandomBytes) begin
      fast_mode = ($urandom_range(0, 3) == 0);
      add_random_dump();
      random_bytes += dump_q.size();
      send_dump();
    end
    fast_mode = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray beat.
    while (sb.owed_reports.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d dumps and %0d bytes with random gaps and one long hold-off.",
             dumps_sent, bytes_taken);
    $display("Checked %0d beats: run %0d, valid %0d, unknown %0d, corrupted %0d,",
             sb.beats_checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
             sb.kind_seen[3]);
    $display("truncated %0d, totals %0d.", sb.kind_seen[4], sb.kind_seen[5]);
    if (sb.errors == 0 && sb.owed_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
